>>> rtl/core/sbpds_pkg.sv
// shared types, constants and helpers for the spectrum bar core
`default_nettype none
package sbpds_pkg;

    localparam int NUM_BANDS      = 8;
    localparam int BAND_W         = 3;
    localparam int BARS_PER_LAYER = 2 * NUM_BANDS;
    localparam int TOTAL_BARS     = 2 * BARS_PER_LAYER;
    localparam int BAR_W          = 5;
    localparam int SUM_W          = 23;
    localparam int X_W            = 17;
    localparam int XS_W           = 23;
    localparam int MOVE_W         = 21;
    localparam int RECIP_W        = 27;
    localparam int RECIP_SH       = 26;
    localparam int DIV_W          = 7;
    localparam int PROD_W         = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [7:0] BIN_LIMIT = 8'd200;

    // input opcodes
    localparam logic [1:0] OP_BIN   = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_FRONT_ATT = 3'd2;
    localparam logic [2:0] REG_BACK_ATT  = 3'd3;
    localparam logic [2:0] REG_FRONT_GN  = 3'd4;
    localparam logic [2:0] REG_BACK_GN   = 3'd5;

    typedef enum logic [1:0] {
        KIND_BIN,
        KIND_FRAME,
        KIND_PLACE
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_QUO,
        ST_MUL,
        ST_OUT
    } t_state;

    // one classified item in the queue
    typedef struct packed {
        t_kind             kind;
        logic [BAND_W-1:0] band;
        logic [15:0]       data;
    } t_entry;

    // configuration seen by the back end
    typedef struct packed {
        logic [11:0] window_width;
        logic [11:0] window_height;
        logic [15:0] front_att;
        logic [15:0] back_att;
        logic [15:0] front_gain;
        logic [15:0] back_gain;
    } t_cfg;

    // band of a bin below the limit
    function automatic logic [BAND_W-1:0] band_of(input logic [7:0] bin);
        logic [BAND_W-1:0] b;
        if (bin < 8'd1)        b = 3'd0;
        else if (bin < 8'd3)   b = 3'd1;
        else if (bin < 8'd5)   b = 3'd2;
        else if (bin < 8'd10)  b = 3'd3;
        else if (bin < 8'd30)  b = 3'd4;
        else if (bin < 8'd50)  b = 3'd5;
        else if (bin < 8'd100) b = 3'd6;
        else                   b = 3'd7;
        return b;
    endfunction

    // band width in bins
    function automatic logic [DIV_W-1:0] band_div(input logic [BAND_W-1:0] b);
        logic [DIV_W-1:0] d;
        case (b)
            3'd0:    d = 7'd1;
            3'd1:    d = 7'd2;
            3'd2:    d = 7'd2;
            3'd3:    d = 7'd5;
            3'd4:    d = 7'd20;
            3'd5:    d = 7'd20;
            3'd6:    d = 7'd50;
            default: d = 7'd100;
        endcase
        return d;
    endfunction

    // floor(2^26 / band width)
    function automatic logic [RECIP_W-1:0] band_recip(input logic [BAND_W-1:0] b);
        logic [RECIP_W-1:0] m;
        case (b)
            3'd0:    m = 27'd67108864;
            3'd1:    m = 27'd33554432;
            3'd2:    m = 27'd33554432;
            3'd3:    m = 27'd13421772;
            3'd4:    m = 27'd3355443;
            3'd5:    m = 27'd3355443;
            3'd6:    m = 27'd1342177;
            default: m = 27'd671088;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sbpds_front.sv
// front end: classifies input items and queues those that do work
`default_nettype none
module sbpds_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [7:0]            i_bin_index,
    input  wire logic [15:0]           i_magnitude,
    input  wire logic signed [15:0]    i_scroll_step,
    output logic                       o_q_valid,
    output logic                       o_q_full,
    output sbpds_pkg::t_entry          o_q_entry,
    input  wire logic                  i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    sbpds_pkg::t_entry r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;

    sbpds_pkg::t_entry w_entry;
    logic              w_keep, w_push, w_pop;

    // classify the incoming item
    always_comb begin
        w_entry.band = sbpds_pkg::band_of(i_bin_index);
        w_entry.data = i_magnitude;
        w_entry.kind = sbpds_pkg::KIND_BIN;
        w_keep       = 1'b0;
        unique case (i_opcode)
            sbpds_pkg::OP_BIN: begin
                w_keep = (i_bin_index < sbpds_pkg::BIN_LIMIT);
            end
            sbpds_pkg::OP_FRAME: begin
                w_entry.kind = sbpds_pkg::KIND_FRAME;
                w_entry.data = i_scroll_step;
                w_keep       = 1'b1;
            end
            sbpds_pkg::OP_PLACE: begin
                w_entry.kind = sbpds_pkg::KIND_PLACE;
                w_keep       = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_q_full  = (r_cnt == CNT_FULL);
    assign o_q_valid = (r_cnt != '0);
    assign o_stall   = o_q_full;
    assign o_q_entry = r_mem[r_rd];
    assign w_push    = i_valid && !o_stall && w_keep;
    assign w_pop     = i_q_pop && o_q_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_entry;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sbpds_back.sv
// back end: band sums, bar placement and the per-bar frame sequencer
`default_nettype none
module sbpds_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sbpds_pkg::t_cfg       i_cfg,
    input  wire logic                  i_q_valid,
    input  wire sbpds_pkg::t_entry     i_q_entry,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_layer,
    output logic [3:0]                 o_bar_index,
    output logic signed [16:0]         o_bar_left,
    output logic [15:0]                o_bar_height,
    output logic                       o_last_bar
);

    localparam int SW = sbpds_pkg::SUM_W;
    localparam int XW = sbpds_pkg::X_W;
    localparam int XS = sbpds_pkg::XS_W;
    localparam int MW = sbpds_pkg::MOVE_W;
    localparam int NB = sbpds_pkg::NUM_BANDS;
    localparam int NL = sbpds_pkg::BARS_PER_LAYER;
    localparam int NT = sbpds_pkg::TOTAL_BARS;
    localparam int BW = sbpds_pkg::BAR_W;
    localparam logic signed [XS-1:0] X_MIN = -XS'(65536);
    localparam logic signed [XS-1:0] X_MAX = XS'(65535);

    sbpds_pkg::t_state r_state, n_state;

    logic [SW-1:0]                    r_sum [NB];
    logic signed [XW-1:0]             r_bx  [NT];
    logic [15:0]                      r_by  [NT];
    logic [BW-1:0]                    r_k;
    logic [sbpds_pkg::PROD_W-1:0]     r_prod;
    logic [15:0]                      r_avg, r_target, r_decay;
    logic signed [XS-1:0]             r_xsum;
    logic signed [MW-1:0]             r_move0, r_move1;
    logic                             r_o_valid;

    logic [sbpds_pkg::BAND_W-1:0]     w_vb;
    logic [SW-1:0]                    w_sum_vb;
    logic [sbpds_pkg::DIV_W-1:0]      w_d;
    logic [SW-1:0]                    w_q;
    logic [SW+sbpds_pkg::DIV_W-1:0]   w_qd;
    logic [SW:0]                      w_rem;
    logic [SW-1:0]                    w_qc;
    logic [27:0]                      w_tgt_p;
    logic [31:0]                      w_dec_p;
    logic signed [32:0]               w_mv0_p, w_mv1_p;
    logic signed [XS-1:0]             w_span, w_wext, w_w1, w_w2, w_xc;
    logic [15:0]                      w_height;
    logic                             w_out_free, w_last;

    // band used by the current bar, mirrored in the upper half
    assign w_vb     = r_k[3] ? ~r_k[2:0] : r_k[2:0];
    assign w_sum_vb = r_sum[w_vb];
    assign w_d      = sbpds_pkg::band_div(w_vb);

    // quotient from the reciprocal product with one correction step
    always_comb begin
        w_q   = r_prod[sbpds_pkg::RECIP_SH +: SW];
        w_qd  = w_q * w_d;
        w_rem = {1'b0, w_sum_vb} - w_qd[SW:0];
        w_qc  = (w_rem >= {{(SW+1-sbpds_pkg::DIV_W){1'b0}}, w_d}) ? w_q + 1'b1 : w_q;
    end

    // per-layer scroll products, floor division by 4096
    assign w_mv0_p = $signed(i_q_entry.data) * $signed({1'b0, i_cfg.front_gain});
    assign w_mv1_p = $signed(i_q_entry.data) * $signed({1'b0, i_cfg.back_gain});

    assign w_tgt_p = r_avg * i_cfg.window_height;
    assign w_dec_p = r_by[r_k] * (r_k[4] ? i_cfg.back_att : i_cfg.front_att);

    // horizontal wrap and clamp, and bar height as the larger of target and decay
    always_comb begin
        w_span = $signed({7'd0, i_cfg.window_width, 4'd0});
        w_wext = $signed({11'd0, i_cfg.window_width});
        w_w1   = (r_xsum + w_wext < 0) ? r_xsum + w_span : r_xsum;
        w_w2   = (w_w1 >= w_span) ? w_w1 - w_span : w_w1;
        if (w_w2 < X_MIN)      w_xc = X_MIN;
        else if (w_w2 > X_MAX) w_xc = X_MAX;
        else                   w_xc = w_w2;
        w_height = (r_target > r_decay) ? r_target : r_decay;
    end

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_last     = (r_k == BW'(NT - 1));

    // next state and queue pop
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            sbpds_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && i_q_entry.kind == sbpds_pkg::KIND_FRAME) begin
                    n_state = sbpds_pkg::ST_DIV;
                end
            end
            sbpds_pkg::ST_DIV: n_state = sbpds_pkg::ST_QUO;
            sbpds_pkg::ST_QUO: n_state = sbpds_pkg::ST_MUL;
            sbpds_pkg::ST_MUL: n_state = sbpds_pkg::ST_OUT;
            sbpds_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = w_last ? sbpds_pkg::ST_IDLE : sbpds_pkg::ST_DIV;
                end
            end
            default: n_state = sbpds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbpds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath and bar state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_o_valid <= 1'b0;
            for (int b = 0; b < NB; b++) r_sum[b] <= '0;
            for (int b = 0; b < NT; b++) begin
                r_bx[b] <= '0;
                r_by[b] <= '0;
            end
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                sbpds_pkg::ST_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_entry.kind)
                            sbpds_pkg::KIND_BIN: begin
                                for (int b = 0; b < NB; b++) begin
                                    if (i_q_entry.band == b[sbpds_pkg::BAND_W-1:0]) begin
                                        r_sum[b] <= ({1'b0, r_sum[b]} + (SW+1)'(i_q_entry.data)
                                                     > {1'b0, sbpds_pkg::SUM_MAX})
                                                    ? sbpds_pkg::SUM_MAX
                                                    : r_sum[b] + SW'(i_q_entry.data);
                                    end
                                end
                            end
                            sbpds_pkg::KIND_PLACE: begin
                                for (int b = 0; b < NL; b++) begin
                                    r_bx[b]      <= $signed({1'b0, 16'(b * i_cfg.window_width)});
                                    r_bx[NL + b] <= $signed({1'b0, 16'(b * i_cfg.window_width)});
                                end
                            end
                            default: begin
                                r_k     <= '0;
                                r_move0 <= w_mv0_p[12 +: MW];
                                r_move1 <= w_mv1_p[12 +: MW];
                            end
                        endcase
                    end
                end
                sbpds_pkg::ST_DIV: begin
                    r_prod <= w_sum_vb * sbpds_pkg::band_recip(w_vb);
                end
                sbpds_pkg::ST_QUO: begin
                    r_avg <= (w_qc > SW'(16'hFFFF)) ? 16'hFFFF : w_qc[15:0];
                end
                sbpds_pkg::ST_MUL: begin
                    r_target <= {2'b00, w_tgt_p[27:14]};
                    r_decay  <= w_dec_p[31:16];
                    r_xsum   <= XS'(r_bx[r_k]) + XS'(r_k[4] ? r_move1 : r_move0);
                end
                sbpds_pkg::ST_OUT: begin
                    if (w_out_free) begin
                        r_by[r_k]    <= w_height;
                        r_bx[r_k]    <= w_xc[XW-1:0];
                        r_o_valid    <= 1'b1;
                        o_layer      <= r_k[4];
                        o_bar_index  <= r_k[3:0];
                        o_bar_left   <= w_xc[XW-1:0];
                        o_bar_height <= w_height;
                        o_last_bar   <= w_last;
                        r_k          <= r_k + 1'b1;
                        if (w_last) begin
                            for (int b = 0; b < NB; b++) r_sum[b] <= '0;
                        end
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;

endmodule
`default_nettype wire

>>> rtl/core/spectrum_bar_peak_decay_scroll_core.sv
// Bin samples stream in at one per cycle through a queue while it is not full; the back end
// steps each bar through its DIV, QUO, MUL and OUT states, holding OUT while the output is
// stalled. A frame item leaves the queue and its 32 bars follow in turn, later items waiting
// in the queue. Place items are handled in the idle state; opcode 3 and bins from 200 up are
// dropped at the front. Synchronous active-low reset clears band sums, bar positions and
// heights, the queue and the registers to their default values.
`default_nettype none
module spectrum_bar_peak_decay_scroll_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [4:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [7:0]            i_bin_index,
    input  wire logic [15:0]           i_magnitude,
    input  wire logic signed [15:0]    i_scroll_step,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_layer,
    output logic [3:0]                 o_bar_index,
    output logic signed [16:0]         o_bar_left,
    output logic [15:0]                o_bar_height,
    output logic                       o_last_bar
);

    sbpds_pkg::t_cfg   r_cfg;
    sbpds_pkg::t_entry w_entry;
    logic              w_q_valid, w_q_full, w_q_pop, w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_width  <= 12'd640;
            r_cfg.window_height <= 12'd480;
            r_cfg.front_att     <= 16'd58982;
            r_cfg.back_att      <= 16'd62259;
            r_cfg.front_gain    <= 16'd4096;
            r_cfg.back_gain     <= 16'd2048;
        end else if (w_wr) begin
            case (paddr[4:2])
                sbpds_pkg::REG_WIDTH:     r_cfg.window_width  <= pwdata[11:0];
                sbpds_pkg::REG_HEIGHT:    r_cfg.window_height <= pwdata[11:0];
                sbpds_pkg::REG_FRONT_ATT: r_cfg.front_att     <= pwdata[15:0];
                sbpds_pkg::REG_BACK_ATT:  r_cfg.back_att      <= pwdata[15:0];
                sbpds_pkg::REG_FRONT_GN:  r_cfg.front_gain    <= pwdata[15:0];
                sbpds_pkg::REG_BACK_GN:   r_cfg.back_gain     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            sbpds_pkg::REG_WIDTH:     prdata = {20'd0, r_cfg.window_width};
            sbpds_pkg::REG_HEIGHT:    prdata = {20'd0, r_cfg.window_height};
            sbpds_pkg::REG_FRONT_ATT: prdata = {16'd0, r_cfg.front_att};
            sbpds_pkg::REG_BACK_ATT:  prdata = {16'd0, r_cfg.back_att};
            sbpds_pkg::REG_FRONT_GN:  prdata = {16'd0, r_cfg.front_gain};
            sbpds_pkg::REG_BACK_GN:   prdata = {16'd0, r_cfg.back_gain};
            default:                  prdata = '0;
        endcase
    end

    sbpds_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_bin_index   (i_bin_index),
        .i_magnitude   (i_magnitude),
        .i_scroll_step (i_scroll_step),
        .o_q_valid     (w_q_valid),
        .o_q_full      (w_q_full),
        .o_q_entry     (w_entry),
        .i_q_pop       (w_q_pop)
    );

    sbpds_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_entry    (w_entry),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_layer      (o_layer),
        .o_bar_index  (o_bar_index),
        .o_bar_left   (o_bar_left),
        .o_bar_height (o_bar_height),
        .o_last_bar   (o_last_bar)
    );

    // the closing bar of a frame is back-layer bar fifteen
    a_last_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_bar) |-> (o_layer && o_bar_index == 4'd15))
        else $error("last bar flag on wrong bar");

    // a full queue is never empty
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> w_q_valid)
        else $error("queue full while empty");

    // front stall follows queue occupancy
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_full)
        else $error("stall without full queue");

endmodule
`default_nettype wire

>>> bench/spectrum_bar_peak_decay_scroll_core_test.sv
// self-checking testbench for the spectrum bar peak decay scroll core
`default_nettype none
module spectrum_bar_peak_decay_scroll_core_test;

    // one input transfer
    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         bin;
        logic [15:0]        mag;
        logic signed [15:0] step;
    } t_item;

    // one bar result
    typedef struct packed {
        logic               layer;
        logic [3:0]         idx;
        logic signed [16:0] left;
        logic [15:0]        height;
        logic               last;
    } t_bar;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic i_valid, o_stall;
    logic [1:0] i_opcode;
    logic [7:0] i_bin_index;
    logic [15:0] i_magnitude;
    logic signed [15:0] i_scroll_step;
    logic o_valid, i_stall;
    logic o_layer;
    logic [3:0] o_bar_index;
    logic signed [16:0] o_bar_left;
    logic [15:0] o_bar_height;
    logic o_last_bar;

    spectrum_bar_peak_decay_scroll_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_bin_index(i_bin_index),
        .i_magnitude(i_magnitude), .i_scroll_step(i_scroll_step),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_layer(o_layer), .o_bar_index(o_bar_index), .o_bar_left(o_bar_left),
        .o_bar_height(o_bar_height), .o_last_bar(o_last_bar)
    );

    // predictor state and configuration copy
    logic [11:0] cfg_width, cfg_height;
    logic [15:0] cfg_att [2];
    logic [15:0] cfg_gain [2];
    logic [22:0] sum_by_band [sbpds_pkg::NUM_BANDS];
    logic signed [16:0] pos_x [sbpds_pkg::TOTAL_BARS];
    logic [15:0] pos_y [sbpds_pkg::TOTAL_BARS];

    t_item pending_items [$];
    t_bar  expected_bars [$];
    int    error_count;
    int    hold_cycles;
    bit    long_hold_req;
    bit    in_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic signed [16:0] clamp17(input longint v);
        if (v < -65536) return 17'sh10000;
        if (v > 65535) return 17'sd65535;
        return v[16:0];
    endfunction

    // band index of a bin, -1 when ignored
    function automatic int bin_band(input int bin);
        if (bin < 1) return 0;
        if (bin < 3) return 1;
        if (bin < 5) return 2;
        if (bin < 10) return 3;
        if (bin < 30) return 4;
        if (bin < 50) return 5;
        if (bin < 100) return 6;
        if (bin < 200) return 7;
        return -1;
    endfunction

    // apply one accepted item to the predictor, queue resulting bars
    task automatic predict_item(input t_item it);
        int bnd, lyr, b, k, vb;
        longint s, span, mv, x, p;
        longint avg, y;
        longint target [sbpds_pkg::NUM_BANDS];
        int widths [sbpds_pkg::NUM_BANDS] = '{1, 2, 2, 5, 20, 20, 50, 100};
        t_bar r;
        case (it.opcode)
            sbpds_pkg::OP_BIN: begin
                bnd = bin_band(it.bin);
                if (bnd >= 0) begin
                    s = longint'(sum_by_band[bnd]) + it.mag;
                    sum_by_band[bnd] = (s > 8388607) ? 23'h7fffff : s[22:0];
                end
            end
            sbpds_pkg::OP_PLACE: begin
                for (b = 0; b < sbpds_pkg::BARS_PER_LAYER; b++) begin
                    pos_x[b] = clamp17(longint'(b) * cfg_width);
                    pos_x[sbpds_pkg::BARS_PER_LAYER + b] = pos_x[b];
                end
            end
            sbpds_pkg::OP_FRAME: begin
                span = longint'(cfg_width) * 16;
                for (b = 0; b < sbpds_pkg::NUM_BANDS; b++) begin
                    avg = sum_by_band[b] / widths[b];
                    if (avg > 65535) avg = 65535;
                    target[b] = (avg * cfg_height) >>> 14;
                end
                for (lyr = 0; lyr < 2; lyr++) begin
                    p = longint'(it.step) * cfg_gain[lyr];
                    mv = (p >= 0) ? (p >>> 12) : -(((-p) + 4095) >>> 12);
                    for (b = 0; b < sbpds_pkg::BARS_PER_LAYER; b++) begin
                        k = lyr * sbpds_pkg::BARS_PER_LAYER + b;
                        vb = (b < sbpds_pkg::NUM_BANDS) ? b
                                                         : (sbpds_pkg::BARS_PER_LAYER - 1 - b);
                        y = (longint'(pos_y[k]) * cfg_att[lyr]) >>> 16;
                        if (target[vb] > y) y = target[vb];
                        if (y > 65535) y = 65535;
                        pos_y[k] = y[15:0];
                        x = longint'(pos_x[k]) + mv;
                        if (x + longint'(cfg_width) < 0) x += span;
                        if (x >= span) x -= span;
                        pos_x[k] = clamp17(x);
                        r.layer = lyr[0];
                        r.idx = b[3:0];
                        r.left = pos_x[k];
                        r.height = pos_y[k];
                        r.last = (k == sbpds_pkg::TOTAL_BARS - 1);
                        expected_bars.push_back(r);
                    end
                end
                for (b = 0; b < sbpds_pkg::NUM_BANDS; b++) sum_by_band[b] = '0;
            end
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: offers queued items, changes at falling edge
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && !in_taken) begin
            // hold payload until the transfer is taken
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
            i_valid <= 1'b1;
            i_opcode <= pending_items[0].opcode;
            i_bin_index <= pending_items[0].bin;
            i_magnitude <= pending_items[0].mag;
            i_scroll_step <= pending_items[0].step;
            void'(pending_items.pop_front());
            send_gap <= gap_len();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // input side: predict on each accepted transfer
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            predict_item({i_opcode, i_bin_index, i_magnitude, i_scroll_step});
    end

    // receiver stall generation, with an occasional long hold-off
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
            hold_cycles <= 0;
        end else if (long_hold_req && hold_cycles == 0 && stall_left == 0) begin
            hold_cycles <= 400;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= (hold_cycles > 1);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left <= gap_len();
            i_stall <= 1'b0;
        end
    end

    // monitor: compare each bar transfer with the oldest expectation
    t_bar want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bars.size() == 0) begin
                $error("unexpected bar transfer");
                error_count++;
            end else begin
                want = expected_bars.pop_front();
                if (o_layer !== want.layer) begin
                    $error("layer exp %0d got %0d", want.layer, o_layer);
                    error_count++;
                end
                if (o_bar_index !== want.idx) begin
                    $error("bar_index exp %0d got %0d", want.idx, o_bar_index);
                    error_count++;
                end
                if (o_bar_left !== want.left) begin
                    $error("bar_left exp %0d got %0d", want.left, o_bar_left);
                    error_count++;
                end
                if (o_bar_height !== want.height) begin
                    $error("bar_height exp %0d got %0d", want.height, o_bar_height);
                    error_count++;
                end
                if (o_last_bar !== want.last) begin
                    $error("last_bar exp %0d got %0d", want.last, o_last_bar);
                    error_count++;
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            sbpds_pkg::REG_WIDTH:     cfg_width = val[11:0];
            sbpds_pkg::REG_HEIGHT:    cfg_height = val[11:0];
            sbpds_pkg::REG_FRONT_ATT: cfg_att[0] = val[15:0];
            sbpds_pkg::REG_BACK_ATT:  cfg_att[1] = val[15:0];
            sbpds_pkg::REG_FRONT_GN:  cfg_gain[0] = val[15:0];
            sbpds_pkg::REG_BACK_GN:   cfg_gain[1] = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drain();
        while (pending_items.size() > 0 || i_valid || expected_bars.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_item mk(input logic [1:0] op, input logic [7:0] bin,
                                 input logic [15:0] mag, input logic [15:0] st);
        t_item it;
        it.opcode = op; it.bin = bin; it.mag = mag; it.step = st;
        return it;
    endfunction

    // random frame: a burst of bins with occasional opcode 3 items, sometimes a place, then a frame
    task automatic queue_random_frame(input int nbins);
        int j;
        for (j = 0; j < nbins; j++) begin
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(mk(2'd3, $urandom, $urandom, $urandom));
            else
                pending_items.push_back(mk(sbpds_pkg::OP_BIN,
                    ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 199),
                    ($urandom_range(0, 3) == 0) ? 16'hffff : $urandom, $urandom));
        end
        if ($urandom_range(0, 4) == 0)
            pending_items.push_back(mk(sbpds_pkg::OP_PLACE, $urandom, $urandom, $urandom));
        pending_items.push_back(mk(sbpds_pkg::OP_FRAME, $urandom, $urandom,
            ($urandom_range(0, 5) == 0) ? 16'h8000 : $urandom));
    endtask

    int ph, n;
    initial begin
        error_count = 0;
        long_hold_req = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_valid = 0; i_opcode = '0; i_bin_index = '0; i_magnitude = '0;
        i_scroll_step = '0; i_stall = 0;
        cfg_width = 12'd640; cfg_height = 12'd480;
        cfg_att[0] = 16'd58982; cfg_att[1] = 16'd62259;
        cfg_gain[0] = 16'd4096; cfg_gain[1] = 16'd2048;
        for (n = 0; n < sbpds_pkg::NUM_BANDS; n++) sum_by_band[n] = '0;
        for (n = 0; n < sbpds_pkg::TOTAL_BARS; n++) begin
            pos_x[n] = '0;
            pos_y[n] = '0;
        end
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every opcode, saturation and wrap
        pending_items.push_back(mk(sbpds_pkg::OP_FRAME, 0, 0, 0));
        pending_items.push_back(mk(sbpds_pkg::OP_PLACE, 0, 0, 0));
        pending_items.push_back(mk(sbpds_pkg::OP_BIN, 0, 16'hffff, 0));
        pending_items.push_back(mk(sbpds_pkg::OP_BIN, 199, 16'hffff, 16'hffff));
        pending_items.push_back(mk(sbpds_pkg::OP_BIN, 200, 16'hffff, 0));
        pending_items.push_back(mk(sbpds_pkg::OP_BIN, 255, 16'hffff, 0));
        pending_items.push_back(mk(2'd3, 8'hff, 16'hffff, 16'hffff));
        for (n = 0; n < 8; n++)
            pending_items.push_back(mk(sbpds_pkg::OP_BIN, 0, 16'hffff, 0));
        pending_items.push_back(mk(sbpds_pkg::OP_FRAME, 0, 0, 16'sh7fff));
        pending_items.push_back(mk(sbpds_pkg::OP_FRAME, 8'hff, 16'hffff, 16'sh8000));
        pending_items.push_back(mk(sbpds_pkg::OP_FRAME, 0, 0, 16'hffff));
        wait_drain();

        // register extremes, with a long receiver hold-off to back up the block
        apb_write(sbpds_pkg::REG_WIDTH, 32'd4095);
        apb_write(sbpds_pkg::REG_HEIGHT, 32'd4095);
        apb_write(sbpds_pkg::REG_FRONT_ATT, 32'd65535);
        apb_write(sbpds_pkg::REG_BACK_ATT, 32'd0);
        apb_write(sbpds_pkg::REG_FRONT_GN, 32'd65535);
        apb_write(sbpds_pkg::REG_BACK_GN, 32'd0);
        pending_items.push_back(mk(sbpds_pkg::OP_PLACE, 0, 0, 0));
        long_hold_req = 1;
        for (ph = 0; ph < 3; ph++) queue_random_frame(10);
        wait (hold_cycles != 0);
        long_hold_req = 0;
        wait_drain();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    apb_write(sbpds_pkg::REG_WIDTH, 32'd16);
                    apb_write(sbpds_pkg::REG_HEIGHT, 32'd4);
                    apb_write(sbpds_pkg::REG_FRONT_GN, 32'd1);
                    apb_write(sbpds_pkg::REG_BACK_GN, 32'd40000);
                end
                1: begin
                    apb_write(sbpds_pkg::REG_WIDTH, 32'd0);
                    apb_write(sbpds_pkg::REG_HEIGHT, 32'd0);
                    apb_write(sbpds_pkg::REG_FRONT_ATT, 32'd0);
                    apb_write(sbpds_pkg::REG_BACK_ATT, 32'd65535);
                end
                2: begin
                    apb_write(sbpds_pkg::REG_WIDTH, {20'hfffff, 12'd1000});
                    apb_write(sbpds_pkg::REG_HEIGHT, 32'd2000);
                    apb_write(sbpds_pkg::REG_FRONT_ATT, $urandom);
                    apb_write(sbpds_pkg::REG_BACK_ATT, $urandom);
                    apb_write(sbpds_pkg::REG_FRONT_GN, $urandom);
                    apb_write(sbpds_pkg::REG_BACK_GN, $urandom);
                end
                default: begin
                    apb_write(sbpds_pkg::REG_WIDTH, 32'd640);
                    apb_write(sbpds_pkg::REG_HEIGHT, 32'd480);
                    apb_write(sbpds_pkg::REG_FRONT_ATT, 32'd58982);
                    apb_write(sbpds_pkg::REG_BACK_ATT, 32'd62259);
                    apb_write(sbpds_pkg::REG_FRONT_GN, 32'd4096);
                    apb_write(sbpds_pkg::REG_BACK_GN, 32'd2048);
                end
            endcase
            pending_items.push_back(mk(sbpds_pkg::OP_PLACE, 0, 0, 0));
            for (n = 0; n < 3; n++) queue_random_frame($urandom_range(5, 25));
            wait_drain();
        end

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
